// File: sv/tpq_pkg.sv
// Shared types and constants for the two-class priority ECN queue.
`default_nettype none

package tpq_pkg;

    localparam logic       OP_ARRIVAL  = 1'b0;
    localparam logic       OP_COMPLETE = 1'b1;

    localparam logic [1:0] EV_ACCEPT   = 2'd0;
    localparam logic [1:0] EV_DROP     = 2'd1;
    localparam logic [1:0] EV_DEPART   = 2'd2;
    localparam logic [1:0] EV_IDLE_CPL = 2'd3;

    localparam logic [1:0] CLS_LOW     = 2'd0;
    localparam logic [1:0] CLS_HIGH    = 2'd1;
    localparam logic [1:0] CLS_NONE    = 2'd2;

    localparam logic [1:0] REG_MAX_HIGH = 2'd0;
    localparam logic [1:0] REG_MAX_LOW  = 2'd1;
    localparam logic [1:0] REG_THR_HIGH = 2'd2;
    localparam logic [1:0] REG_THR_LOW  = 2'd3;

    localparam logic [23:0] MAX_BYTES_RESET = 24'd65536;
    localparam logic [23:0] THRESHOLD_RESET = 24'd32768;

    typedef struct packed {
        logic        operation;
        logic        packet_priority;
        logic [15:0] packet_bytes;
        logic [15:0] packet_tag;
        logic        random_bit;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] out_tag;
        logic [15:0] out_bytes;
        logic        out_priority;
        logic        ce_marked;
        logic [23:0] bytes_high_now;
        logic [23:0] bytes_low_now;
        logic [31:0] drops_total;
        logic [31:0] departures_total;
    } out_word_t;

    typedef struct packed {
        logic [23:0] max_bytes_high;
        logic [23:0] max_bytes_low;
        logic [23:0] mark_threshold_high;
        logic [23:0] mark_threshold_low;
    } cfg_t;

    typedef struct packed {
        logic capture_in;
        logic do_read;
        logic do_idle_cpl;
        logic do_arrival;
        logic do_pop;
        logic do_start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic in_op;
        logic serving_none;
        logic start_needed;
    } status_t;

endpackage

`default_nettype wire

// File: sv/tpq_regs.sv
// APB configuration registers: class byte limits and CE thresholds.
`default_nettype none

module tpq_regs (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output tpq_pkg::cfg_t       cfg
);

    tpq_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_bytes_high      <= tpq_pkg::MAX_BYTES_RESET;
            cfg_reg.max_bytes_low       <= tpq_pkg::MAX_BYTES_RESET;
            cfg_reg.mark_threshold_high <= tpq_pkg::THRESHOLD_RESET;
            cfg_reg.mark_threshold_low  <= tpq_pkg::THRESHOLD_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                tpq_pkg::REG_MAX_HIGH: cfg_reg.max_bytes_high      <= pwdata[23:0];
                tpq_pkg::REG_MAX_LOW:  cfg_reg.max_bytes_low       <= pwdata[23:0];
                tpq_pkg::REG_THR_HIGH: cfg_reg.mark_threshold_high <= pwdata[23:0];
                tpq_pkg::REG_THR_LOW:  cfg_reg.mark_threshold_low  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            tpq_pkg::REG_MAX_HIGH: prdata = {8'd0, cfg_reg.max_bytes_high};
            tpq_pkg::REG_MAX_LOW:  prdata = {8'd0, cfg_reg.max_bytes_low};
            tpq_pkg::REG_THR_HIGH: prdata = {8'd0, cfg_reg.mark_threshold_high};
            tpq_pkg::REG_THR_LOW:  prdata = {8'd0, cfg_reg.mark_threshold_low};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/tpq_ctrl.sv
// Sequencer for the queue: accept, decide or pop, start service, deliver.
`default_nettype none

module tpq_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire tpq_pkg::status_t stat,
    output tpq_pkg::cmd_t         cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ARR   = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.capture_in = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (stat.in_op == tpq_pkg::OP_ARRIVAL)
                    begin
                        state_next = S_ARR;
                    end
                    else if (stat.serving_none)
                    begin
                        cmd.do_idle_cpl = 1'b1;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        cmd.do_read = 1'b1;
                        state_next  = S_POP;
                    end
                end
            end
            S_ARR:
            begin
                cmd.do_arrival = 1'b1;
                state_next     = stat.start_needed ? S_START : S_FIN;
            end
            S_POP:
            begin
                cmd.do_pop = 1'b1;
                state_next = S_START;
            end
            S_START:
            begin
                cmd.do_start = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a pending word is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten while stalled");

    // each arrival passes through the decision step right after capture
    a_arr_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stat.in_op == tpq_pkg::OP_ARRIVAL) |=> state_reg == S_ARR)
        else $error("arrival not decided after capture");

endmodule

`default_nettype wire

// File: sv/tpq_datapath.sv
// Queue datapath: descriptor memories, pointers, byte counts, counters, output word.
`default_nettype none

module tpq_datapath #(
    parameter int FIFO_DEPTH = 256,
    parameter int TAG_BITS   = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tpq_pkg::in_word_t in_word,
    input  wire tpq_pkg::cfg_t     cfg,
    input  wire tpq_pkg::cmd_t     cmd,
    output tpq_pkg::status_t       stat,
    output tpq_pkg::out_word_t     out_word
);

    localparam int TW = (TAG_BITS < 16) ? TAG_BITS : 16;
    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int DW = TW + 16;

    logic [DW-1:0] mem_high [FIFO_DEPTH];
    logic [DW-1:0] mem_low  [FIFO_DEPTH];
    logic [DW-1:0] rd_high_reg;
    logic [DW-1:0] rd_low_reg;

    tpq_pkg::in_word_t  in_reg;
    tpq_pkg::out_word_t out_reg;

    logic [AW-1:0] high_head_reg, high_tail_reg, low_head_reg, low_tail_reg;
    logic [CW-1:0] high_count_reg, low_count_reg;
    logic [23:0]   high_bytes_reg, low_bytes_reg;
    logic [1:0]    serving_reg;
    logic          mark_reg;
    logic [31:0]   drop_cnt_reg, dep_cnt_reg;

    logic [1:0]    ev_kind_reg;
    logic [15:0]   ev_tag_reg, ev_bytes_reg;
    logic          ev_prio_reg, ev_ce_reg;

    logic          arr_high;
    logic [23:0]   sel_bytes, sel_limit;
    logic          sel_full;
    logic [24:0]   sum1;
    logic [25:0]   sum2;
    logic          drop;
    logic          push;
    logic [DW-1:0] pop_data;
    logic [15:0]   pop_size;
    logic [15:0]   in_tag16;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign arr_high  = in_reg.packet_priority;
    assign sel_bytes = arr_high ? high_bytes_reg : low_bytes_reg;
    assign sel_limit = arr_high ? cfg.max_bytes_high : cfg.max_bytes_low;
    assign sel_full  = arr_high ? (high_count_reg == CW'(FIFO_DEPTH))
                                : (low_count_reg == CW'(FIFO_DEPTH));
    assign sum1      = {1'b0, sel_bytes} + {9'd0, in_reg.packet_bytes};
    assign sum2      = {2'b0, sel_bytes} + {9'd0, in_reg.packet_bytes, 1'b0};
    assign drop      = (sum1 > {1'b0, sel_limit})
                    || ((sum2 > {2'b0, sel_limit}) && in_reg.random_bit)
                    || sel_full;
    assign push      = !drop;
    assign in_tag16  = 16'(in_reg.packet_tag[TW-1:0]);

    assign pop_data  = (serving_reg == tpq_pkg::CLS_HIGH) ? rd_high_reg : rd_low_reg;
    assign pop_size  = pop_data[15:0];

    assign stat.in_op        = in_word.operation;
    assign stat.serving_none = (serving_reg == tpq_pkg::CLS_NONE);
    assign stat.start_needed = push && (serving_reg == tpq_pkg::CLS_NONE);

    assign out_word = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.do_arrival && push && arr_high)
        begin
            mem_high[high_tail_reg] <= {in_reg.packet_tag[TW-1:0], in_reg.packet_bytes};
        end
        if (cmd.do_read)
        begin
            rd_high_reg <= mem_high[high_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_arrival && push && !arr_high)
        begin
            mem_low[low_tail_reg] <= {in_reg.packet_tag[TW-1:0], in_reg.packet_bytes};
        end
        if (cmd.do_read)
        begin
            rd_low_reg <= mem_low[low_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_in)
        begin
            in_reg <= in_word;
        end
        if (cmd.do_idle_cpl)
        begin
            ev_kind_reg  <= tpq_pkg::EV_IDLE_CPL;
            ev_tag_reg   <= 16'd0;
            ev_bytes_reg <= 16'd0;
            ev_prio_reg  <= 1'b0;
            ev_ce_reg    <= 1'b0;
        end
        else if (cmd.do_arrival)
        begin
            ev_kind_reg  <= drop ? tpq_pkg::EV_DROP : tpq_pkg::EV_ACCEPT;
            ev_tag_reg   <= in_tag16;
            ev_bytes_reg <= in_reg.packet_bytes;
            ev_prio_reg  <= arr_high;
            ev_ce_reg    <= 1'b0;
        end
        else if (cmd.do_pop)
        begin
            ev_kind_reg  <= tpq_pkg::EV_DEPART;
            ev_tag_reg   <= 16'(pop_data[DW-1:16]);
            ev_bytes_reg <= pop_size;
            ev_prio_reg  <= (serving_reg == tpq_pkg::CLS_HIGH);
            ev_ce_reg    <= mark_reg;
        end
        if (cmd.load_out)
        begin
            out_reg.event_kind       <= ev_kind_reg;
            out_reg.out_tag          <= ev_tag_reg;
            out_reg.out_bytes        <= ev_bytes_reg;
            out_reg.out_priority     <= ev_prio_reg;
            out_reg.ce_marked        <= ev_ce_reg;
            out_reg.bytes_high_now   <= high_bytes_reg;
            out_reg.bytes_low_now    <= low_bytes_reg;
            out_reg.drops_total      <= drop_cnt_reg;
            out_reg.departures_total <= dep_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_head_reg  <= '0;
            high_tail_reg  <= '0;
            high_count_reg <= '0;
            low_head_reg   <= '0;
            low_tail_reg   <= '0;
            low_count_reg  <= '0;
            high_bytes_reg <= 24'd0;
            low_bytes_reg  <= 24'd0;
            serving_reg    <= tpq_pkg::CLS_NONE;
            mark_reg       <= 1'b0;
            drop_cnt_reg   <= 32'd0;
            dep_cnt_reg    <= 32'd0;
        end
        else
        begin
            if (cmd.do_arrival)
            begin
                if (drop)
                begin
                    drop_cnt_reg <= drop_cnt_reg + 32'd1;
                end
                else if (arr_high)
                begin
                    high_tail_reg  <= ptr_inc(high_tail_reg);
                    high_count_reg <= high_count_reg + CW'(1);
                    high_bytes_reg <= sum1[23:0];
                end
                else
                begin
                    low_tail_reg  <= ptr_inc(low_tail_reg);
                    low_count_reg <= low_count_reg + CW'(1);
                    low_bytes_reg <= sum1[23:0];
                end
            end
            if (cmd.do_pop)
            begin
                if (serving_reg == tpq_pkg::CLS_HIGH)
                begin
                    high_head_reg  <= ptr_inc(high_head_reg);
                    high_count_reg <= high_count_reg - CW'(1);
                    high_bytes_reg <= high_bytes_reg - {8'd0, pop_size};
                end
                else
                begin
                    low_head_reg  <= ptr_inc(low_head_reg);
                    low_count_reg <= low_count_reg - CW'(1);
                    low_bytes_reg <= low_bytes_reg - {8'd0, pop_size};
                end
                dep_cnt_reg <= dep_cnt_reg + 32'd1;
                serving_reg <= tpq_pkg::CLS_NONE;
            end
            if (cmd.do_start)
            begin
                if (high_count_reg != '0)
                begin
                    serving_reg <= tpq_pkg::CLS_HIGH;
                    mark_reg    <= (high_bytes_reg > cfg.mark_threshold_high);
                end
                else if (low_count_reg != '0)
                begin
                    serving_reg <= tpq_pkg::CLS_LOW;
                    mark_reg    <= (low_bytes_reg > cfg.mark_threshold_low);
                end
                else
                begin
                    serving_reg <= tpq_pkg::CLS_NONE;
                    mark_reg    <= 1'b0;
                end
            end
        end
    end

    a_high_bound: assert property (@(posedge clk) disable iff (!rst_n)
        high_count_reg <= CW'(FIFO_DEPTH) && low_count_reg <= CW'(FIFO_DEPTH))
        else $error("descriptor count beyond depth");

    a_serve_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (serving_reg == tpq_pkg::CLS_HIGH |-> high_count_reg != '0)
        and (serving_reg == tpq_pkg::CLS_LOW |-> low_count_reg != '0))
        else $error("serving an empty class");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (high_count_reg == '0 |-> high_head_reg == high_tail_reg)
        and (low_count_reg == '0 |-> low_head_reg == low_tail_reg))
        else $error("empty fifo with split pointers");

    a_pop_served: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_pop |-> $past(cmd.do_read))
        else $error("pop without a descriptor read");

endmodule

`default_nettype wire

// File: sv/two_priority_ecn_droptail_queue.sv
// Top level of the two-class strict-priority egress queue with ECN marking.
//
// in_word carries one event: a packet arrival (class, size, tag, coin) or a
// completion of the packet in service. out_word returns exactly one word per
// event: accepted, dropped, departed or completion-while-idle, with the byte
// counts and wrapping drop/departure totals after that event.
// The APB port holds the two class byte limits and two CE thresholds at
// byte addresses 0, 4, 8 and 12; pready is tied high.
// One event is in flight at a time. out_valid rises once the finish step
// has loaded the word: a completion while idle goes straight there, an
// arrival is decided first (and starts service if needed), and a departure
// does the registered descriptor read, pop and service start before it.
// in_ready returns at the edge that loads the word; the descriptor memory
// read and the service-start step make an event take longer.
// While out_ready is low the finished word holds; the next event may be
// accepted and runs until its own word is ready to load.
// Reset empties both FIFOs, clears counts and totals, and restores the
// register defaults; the descriptor memories need no clearing.
`default_nettype none

module two_priority_ecn_droptail_queue #(
    parameter int FIFO_DEPTH = 256,
    parameter int TAG_BITS   = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire tpq_pkg::in_word_t  in_word,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tpq_pkg::out_word_t      out_word,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    tpq_pkg::cfg_t    cfg;
    tpq_pkg::cmd_t    cmd;
    tpq_pkg::status_t stat;

    tpq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tpq_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .out_word (out_word)
    );

endmodule

`default_nettype wire

// File: bench/two_priority_ecn_droptail_queue_tb.sv
// Self-checking bench for the two-class priority ECN queue: random and directed events.
`timescale 1ns / 100ps

module two_priority_ecn_droptail_queue_tb;

    localparam int QUEUE_DEPTH    = 256;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] size;
    } desc_t;

    class queue_event_checker;
        desc_t              high_q[$];
        desc_t              low_q[$];
        int unsigned        high_bytes;
        int unsigned        low_bytes;
        logic [1:0]         serving;
        logic               mark;
        logic [31:0]        drops;
        logic [31:0]        departs;
        logic [23:0]        limit_high;
        logic [23:0]        limit_low;
        logic [23:0]        thr_high;
        logic [23:0]        thr_low;
        tpq_pkg::out_word_t expected_events[$];
        int                 errors;
        int                 checked;
        int                 kind_seen[4];
        int                 marks_seen;

        function new();
            high_bytes = 0;
            low_bytes  = 0;
            serving    = tpq_pkg::CLS_NONE;
            mark       = 1'b0;
            drops      = '0;
            departs    = '0;
            limit_high = tpq_pkg::MAX_BYTES_RESET;
            limit_low  = tpq_pkg::MAX_BYTES_RESET;
            thr_high   = tpq_pkg::THRESHOLD_RESET;
            thr_low    = tpq_pkg::THRESHOLD_RESET;
            errors     = 0;
            checked    = 0;
            marks_seen = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 100)
                $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        function void set_reg(input logic [1:0] idx, input logic [23:0] value);
            case (idx)
                tpq_pkg::REG_MAX_HIGH: limit_high = value;
                tpq_pkg::REG_MAX_LOW:  limit_low  = value;
                tpq_pkg::REG_THR_HIGH: thr_high   = value;
                tpq_pkg::REG_THR_LOW:  thr_low    = value;
                default: ;
            endcase
        endfunction

        function void start_service();
            mark = 1'b0;
            if (high_q.size() != 0)
            begin
                serving = tpq_pkg::CLS_HIGH;
                mark    = high_bytes > thr_high;
            end
            else if (low_q.size() != 0)
            begin
                serving = tpq_pkg::CLS_LOW;
                mark    = low_bytes > thr_low;
            end
            else
            begin
                serving = tpq_pkg::CLS_NONE;
            end
        endfunction

        function void note_input(input tpq_pkg::in_word_t w);
            tpq_pkg::out_word_t want;
            desc_t              d;
            int unsigned        held;
            int unsigned        cap;
            int unsigned        size;
            int unsigned        depth;
            logic               drop;
            want = '0;
            if (w.operation == tpq_pkg::OP_ARRIVAL)
            begin
                size  = 32'(w.packet_bytes);
                held  = w.packet_priority ? high_bytes : low_bytes;
                cap   = w.packet_priority ? 32'(limit_high) : 32'(limit_low);
                depth = w.packet_priority ? high_q.size() : low_q.size();
                drop  = (held + size > cap) || ((held + 2 * size > cap) && w.random_bit)
                        || (depth >= QUEUE_DEPTH);
                want.out_tag      = w.packet_tag;
                want.out_bytes    = w.packet_bytes;
                want.out_priority = w.packet_priority;
                if (drop)
                begin
                    want.event_kind = tpq_pkg::EV_DROP;
                    drops++;
                end
                else
                begin
                    d.tag  = w.packet_tag;
                    d.size = w.packet_bytes;
                    if (w.packet_priority)
                    begin
                        high_q.push_back(d);
                        high_bytes = (high_bytes + size) & 24'hFFFFFF;
                    end
                    else
                    begin
                        low_q.push_back(d);
                        low_bytes = (low_bytes + size) & 24'hFFFFFF;
                    end
                    want.event_kind = tpq_pkg::EV_ACCEPT;
                    if (serving == tpq_pkg::CLS_NONE)
                        start_service();
                end
            end
            else if (serving == tpq_pkg::CLS_NONE)
            begin
                want.event_kind = tpq_pkg::EV_IDLE_CPL;
            end
            else
            begin
                if (serving == tpq_pkg::CLS_HIGH)
                begin
                    d = high_q.pop_front();
                    high_bytes = (high_bytes - d.size) & 24'hFFFFFF;
                end
                else
                begin
                    d = low_q.pop_front();
                    low_bytes = (low_bytes - d.size) & 24'hFFFFFF;
                end
                departs++;
                want.event_kind   = tpq_pkg::EV_DEPART;
                want.out_tag      = d.tag;
                want.out_bytes    = d.size;
                want.out_priority = (serving == tpq_pkg::CLS_HIGH);
                want.ce_marked    = mark;
                serving = tpq_pkg::CLS_NONE;
                start_service();
            end
            want.bytes_high_now   = high_bytes[23:0];
            want.bytes_low_now    = low_bytes[23:0];
            want.drops_total      = drops;
            want.departures_total = departs;
            expected_events.push_back(want);
        endfunction

        task cmp(input string field, input logic [31:0] got, input logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                 checked, field, got, want));
        endtask

        task check_result(input tpq_pkg::out_word_t got);
            tpq_pkg::out_word_t want;
            checked++;
            if (expected_events.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing outstanding", checked));
                return;
            end
            want = expected_events.pop_front();
            kind_seen[want.event_kind]++;
            if (want.ce_marked)
                marks_seen++;
            cmp("event_kind", 32'(got.event_kind), 32'(want.event_kind));
            cmp("out_tag", 32'(got.out_tag), 32'(want.out_tag));
            cmp("out_bytes", 32'(got.out_bytes), 32'(want.out_bytes));
            cmp("out_priority", 32'(got.out_priority), 32'(want.out_priority));
            cmp("ce_marked", 32'(got.ce_marked), 32'(want.ce_marked));
            cmp("bytes_high_now", 32'(got.bytes_high_now), 32'(want.bytes_high_now));
            cmp("bytes_low_now", 32'(got.bytes_low_now), 32'(want.bytes_low_now));
            cmp("drops_total", got.drops_total, want.drops_total);
            cmp("departures_total", got.departures_total, want.departures_total);
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    tpq_pkg::in_word_t  in_word;
    logic               out_valid;
    logic               out_ready;
    tpq_pkg::out_word_t out_word;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    queue_event_checker sb = new();

    bit bursty = 1'b1;
    bit calm   = 1'b0;
    int words_sent = 0;
    int settings_used = 0;
    int quiet_cycles;

    two_priority_ecn_droptail_queue #(
        .FIFO_DEPTH (QUEUE_DEPTH),
        .TAG_BITS   (16)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_input(in_word);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_word);
    end

    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic send_word(input tpq_pkg::in_word_t w);
        if (bursty && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_arrival(input logic prio, input logic [15:0] bytes,
                                input logic [15:0] tag, input logic coin);
        tpq_pkg::in_word_t w;
        w.operation       = tpq_pkg::OP_ARRIVAL;
        w.packet_priority = prio;
        w.packet_bytes    = bytes;
        w.packet_tag      = tag;
        w.random_bit      = coin;
        send_word(w);
    endtask

    task automatic send_completion();
        tpq_pkg::in_word_t w;
        w              = tpq_pkg::in_word_t'($urandom());
        w.operation    = tpq_pkg::OP_COMPLETE;
        send_word(w);
    endtask

    function automatic tpq_pkg::in_word_t random_word(input int arrival_pct);
        tpq_pkg::in_word_t w;
        int unsigned       held;
        int unsigned       cap;
        int unsigned       room;
        w.operation       = ($urandom_range(0, 99) < arrival_pct) ? tpq_pkg::OP_ARRIVAL
                                                                  : tpq_pkg::OP_COMPLETE;
        w.packet_priority = 1'($urandom_range(0, 1));
        w.packet_tag      = 16'($urandom());
        w.random_bit      = 1'($urandom_range(0, 1));
        held = w.packet_priority ? sb.high_bytes : sb.low_bytes;
        cap  = w.packet_priority ? 32'(sb.limit_high) : 32'(sb.limit_low);
        room = (held >= cap) ? 0 : cap - held;
        if (room > 65535)
            room = 65535;
        case ($urandom_range(0, 9))
            0:       w.packet_bytes = 16'd0;
            1:       w.packet_bytes = 16'hFFFF;
            2:       w.packet_bytes = room[15:0];
            3:       w.packet_bytes = room[16:1];
            4:       w.packet_bytes = room[16:1] + 16'd1;
            5, 6:    w.packet_bytes = 16'($urandom_range(0, 65535));
            default: w.packet_bytes = 16'($urandom_range(0, 4095));
        endcase
        return w;
    endfunction

    task automatic run_random(input int count, input int arrival_pct);
        repeat (count) send_word(random_word(arrival_pct));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {8'h00, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_reg(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[23:0] !== value)
            sb.report($sformatf("register %0d read 0x%0h, expected 0x%0h",
                                idx, prdata[23:0], value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [23:0] max_high, input logic [23:0] max_low,
                             input logic [23:0] thr_high, input logic [23:0] thr_low);
        write_reg(tpq_pkg::REG_MAX_HIGH, max_high);
        write_reg(tpq_pkg::REG_MAX_LOW, max_low);
        write_reg(tpq_pkg::REG_THR_HIGH, thr_high);
        write_reg(tpq_pkg::REG_THR_LOW, thr_low);
        settings_used++;
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_word  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset defaults: limits 65536, thresholds 32768
        send_completion();
        send_arrival(1'b1, 16'd0, 16'h0000, 1'b0);
        send_arrival(1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_arrival(1'b0, 16'd1, 16'hA5A5, 1'b1);
        send_arrival(1'b0, 16'd1, 16'h5A5A, 1'b0);
        send_arrival(1'b0, 16'd0, 16'h1234, 1'b1);
        send_arrival(1'b0, 16'd1, 16'h4321, 1'b0);
        send_arrival(1'b1, 16'd40000, 16'h8001, 1'b0);
        send_arrival(1'b1, 16'd30000, 16'h8002, 1'b0);
        repeat (6) send_completion();
        // exactly at threshold: no mark; twice size equals limit with coin set
        send_arrival(1'b1, 16'd32768, 16'h7FFF, 1'b1);
        send_arrival(1'b1, 16'd1, 16'hFFFE, 1'b0);
        repeat (3) send_completion();

        drain();
        configure(24'd0, 24'd0, 24'd0, 24'd0);
        run_random(60, 60);

        drain();
        while (sb.serving != tpq_pkg::CLS_NONE) send_completion();
        drain();
        // descriptor FIFOs overflow while byte limits never bind
        configure(24'hFFFFFF, 24'hFFFFFF, 24'd20000, 24'd20000);
        repeat (QUEUE_DEPTH + 4)
            send_arrival(1'b1, 16'($urandom_range(0, 255)), 16'($urandom()),
                         1'($urandom_range(0, 1)));
        repeat (QUEUE_DEPTH + 4)
            send_arrival(1'b0, 16'($urandom_range(0, 255)), 16'($urandom()),
                         1'($urandom_range(0, 1)));
        repeat (2 * QUEUE_DEPTH + 3) send_completion();

        drain();
        configure(24'd100000, 24'd30000, 24'd50000, 24'd1000);
        run_random(200, 55);

        drain();
        configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        run_random(120, 55);

        drain();
        configure(24'd131072, 24'd65536, 24'd0, 24'd0);
        run_random(150, 50);

        drain();
        configure(24'($urandom_range(0, 200000)), 24'($urandom_range(0, 200000)),
                  24'($urandom_range(0, 100000)), 24'($urandom_range(0, 100000)));
        bursty = 1'b0;
        calm   = 1'b1;
        run_random(100, 55);

        drain();
        if (sb.expected_events.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_events.size()));
        $display("Ran %0d events over %0d register settings; %0d results compared.",
                 words_sent, settings_used, sb.checked);
        $display("Events: %0d queued, %0d dropped, %0d departed (%0d CE marked), %0d idle.",
                 sb.kind_seen[tpq_pkg::EV_ACCEPT], sb.kind_seen[tpq_pkg::EV_DROP],
                 sb.kind_seen[tpq_pkg::EV_DEPART], sb.marks_seen,
                 sb.kind_seen[tpq_pkg::EV_IDLE_CPL]);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
